// ----- hw/rtl/rtfp_pkg.sv -----
`default_nettype none

package rtfp_pkg;

   // Sync pattern as it appears in the byte history, oldest byte in the top bits.
   localparam logic [63:0] SYNC_PATTERN = 64'h0201_0403_0605_0807;

   // Bytes the sync pattern contributes to a frame span.
   localparam logic [15:0] SYNC_LEN = 16'd8;
   localparam logic [15:0] SPAN_MAX = 16'hFFFF;

   // Header words: total length, TLV count and the number of words in all.
   localparam logic [3:0] HDR_TOTAL_LEN = 4'd1;
   localparam logic [3:0] HDR_NUM_TLVS  = 4'd6;
   localparam logic [3:0] HDR_WORDS     = 4'd9;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_TLV_HDR = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_VERDICT = 2'd3;

   // Depth of the result queue; it must hold two results of one byte.
   localparam int RSP_DEPTH = 4;

   typedef enum logic [5:0] {
      PH_HUNT    = 6'b000001,
      PH_HEADER  = 6'b000010,
      PH_TYPE    = 6'b000100,
      PH_LENGTH  = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic        last;
      logic        frame_ok;
      logic        tlv_last_byte;
      logic [31:0] tlv_kind;
      logic [31:0] value;
      logic [3:0]  word_index;
      logic [1:0]  kind;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- hw/rtl/radar_tlv_frame_parser.sv -----
`default_nettype none

// Radar TLV frame parser. The block takes one byte of the radar UART stream per request
// on the req_ channel (req_tlast marks the final byte of a received buffer) and hunts for
// the sync pattern 02 01 04 03 06 05 08 07. After the pattern it assembles the nine
// little-endian 32-bit header words and reports each one, then walks the TLV records that
// header word 6 announces: for each it reports the length word tagged with the type, then
// every payload byte tagged with the type, with a flag on the final byte. The next sync
// pattern or the end of a buffer closes the frame with a verdict that carries the observed
// span (saturated at 65535) and says whether it matches the total-length header word. The
// buffer end also clears the sync history, so a pattern never spans two buffers. Timing:
// a byte is held in an input register and parsed from there; its results are registered
// in the result queue before they appear. One byte is accepted every cycle while the
// consumer keeps up. A byte that both ends a frame and closes a buffer yields two
// results, which leave the four-entry result queue one at a time; the parse stage waits
// only when fewer than two queue entries are free.
module radar_tlv_frame_parser (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_byte
   input  wire         req_tlast,   // buffer_end
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] word_index, [35:4] value, [67:36] tlv_kind,
                                    // [68] tlv_last_byte, [69] frame_ok, [71:70] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last result caused by one request
);

   import rtfp_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   // Input register.
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // Parser state.
   logic [55:0] sync_ff, sync_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] accum_ff, accum_in;
   logic [1:0]  biw_ff, biw_in;
   logic [3:0]  hwc_ff, hwc_in;
   logic [31:0] decl_len_ff, decl_len_in;
   logic [31:0] tlvs_ff, tlvs_in;
   logic [31:0] tlv_type_ff, tlv_type_in;
   logic [31:0] pay_rem_ff, pay_rem_in;
   logic [15:0] span_ff, span_in;

   // Result queue.
   rsp_item_type           rsp_q_ff [RSP_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // Parse stage.
   logic         proc_fire;
   logic         rsp_pop;
   logic [63:0]  sync_cat;
   logic         sync_hit;
   logic         frame_open;
   logic [15:0]  span_inc;
   logic [15:0]  vspan;
   logic [31:0]  word_val;
   logic [31:0]  tlvs_dec;
   logic [31:0]  pay_dec;
   logic [3:0]   hwc_inc;
   logic [1:0]   n_res;
   rsp_item_type res_a, res_b;

   // The queue must have room for the worst case of two results from one byte.
   assign proc_fire  = in_vld_ff && (cnt_ff <= CNT_W'(RSP_DEPTH - 2));
   assign req_tready = !in_vld_ff || proc_fire;
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      sync_in     = sync_ff;
      phase_in    = phase_ff;
      accum_in    = accum_ff;
      biw_in      = biw_ff;
      hwc_in      = hwc_ff;
      decl_len_in = decl_len_ff;
      tlvs_in     = tlvs_ff;
      tlv_type_in = tlv_type_ff;
      pay_rem_in  = pay_rem_ff;
      span_in     = span_ff;
      res_a       = '0;
      res_b       = '0;
      n_res       = 2'd0;
      vspan       = '0;

      sync_cat   = {sync_ff, in_byte_ff};
      sync_hit   = (sync_cat == SYNC_PATTERN);
      frame_open = (phase_ff != PH_HUNT);
      span_inc   = (span_ff == SPAN_MAX) ? span_ff : span_ff + 16'd1;
      word_val   = accum_ff | ({24'd0, in_byte_ff} << {biw_ff, 3'b000});
      hwc_inc    = hwc_ff + 4'd1;
      tlvs_dec   = (tlvs_ff != 32'd0) ? tlvs_ff - 32'd1 : tlvs_ff;
      pay_dec    = (pay_rem_ff != 32'd0) ? pay_rem_ff - 32'd1 : pay_rem_ff;

      sync_in = sync_cat[55:0];

      if (sync_hit) begin
         // The sync byte closes the open frame and opens a new one.
         if (frame_open) begin
            vspan          = (span_inc == SPAN_MAX) ? SPAN_MAX : span_inc - SYNC_LEN;
            res_a.kind     = KIND_VERDICT;
            res_a.value    = {16'd0, vspan};
            res_a.frame_ok = (hwc_ff >= 4'd2) && ({16'd0, vspan} == decl_len_ff);
            n_res          = 2'd1;
         end
         span_in     = SYNC_LEN;
         phase_in    = PH_HEADER;
         accum_in    = '0;
         biw_in      = '0;
         hwc_in      = '0;
         decl_len_in = '0;
         tlvs_in     = '0;
         tlv_type_in = '0;
         pay_rem_in  = '0;
      end else if (frame_open) begin
         span_in = span_inc;
         case (phase_ff)
            PH_PAYLOAD: begin
               res_a.kind          = KIND_PAYLOAD;
               res_a.value         = {24'd0, in_byte_ff};
               res_a.tlv_kind      = tlv_type_ff;
               res_a.tlv_last_byte = (pay_rem_ff == 32'd1);
               n_res               = 2'd1;
               pay_rem_in          = pay_dec;
               if (pay_dec == 32'd0) begin
                  tlvs_in  = tlvs_dec;
                  phase_in = (tlvs_dec != 32'd0) ? PH_TYPE : PH_DONE;
               end
            end
            PH_HEADER, PH_TYPE, PH_LENGTH: begin
               if (biw_ff == 2'd3) begin
                  accum_in = '0;
                  biw_in   = '0;
                  if (phase_ff == PH_HEADER) begin
                     res_a.kind       = KIND_HEADER;
                     res_a.word_index = hwc_ff;
                     res_a.value      = word_val;
                     n_res            = 2'd1;
                     if (hwc_ff == HDR_TOTAL_LEN) begin
                        decl_len_in = word_val;
                     end
                     if (hwc_ff == HDR_NUM_TLVS) begin
                        tlvs_in = word_val;
                     end
                     hwc_in = hwc_inc;
                     if (hwc_inc >= HDR_WORDS) begin
                        phase_in = (tlvs_in != 32'd0) ? PH_TYPE : PH_DONE;
                     end
                  end else if (phase_ff == PH_TYPE) begin
                     tlv_type_in = word_val;
                     phase_in    = PH_LENGTH;
                  end else begin
                     res_a.kind     = KIND_TLV_HDR;
                     res_a.value    = word_val;
                     res_a.tlv_kind = tlv_type_ff;
                     n_res          = 2'd1;
                     pay_rem_in     = word_val;
                     if (word_val == 32'd0) begin
                        tlvs_in  = tlvs_dec;
                        phase_in = (tlvs_dec != 32'd0) ? PH_TYPE : PH_DONE;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end else begin
                  accum_in = word_val;
                  biw_in   = biw_ff + 2'd1;
               end
            end
            default: begin
               // Trailing bytes after the last TLV are dropped.
            end
         endcase
      end

      if (in_end_ff) begin
         // A buffer end closes whatever frame is open after this byte.
         if (phase_in != PH_HUNT) begin
            if (n_res == 2'd0) begin
               res_a.kind     = KIND_VERDICT;
               res_a.value    = {16'd0, span_in};
               res_a.frame_ok = (hwc_in >= 4'd2) && ({16'd0, span_in} == decl_len_in);
            end else begin
               res_b.kind     = KIND_VERDICT;
               res_b.value    = {16'd0, span_in};
               res_b.frame_ok = (hwc_in >= 4'd2) && ({16'd0, span_in} == decl_len_in);
            end
            n_res = n_res + 2'd1;
         end
         phase_in = PH_HUNT;
         sync_in  = '0;
      end

      if (n_res == 2'd1) begin
         res_a.last = 1'b1;
      end
      if (n_res == 2'd2) begin
         res_b.last = 1'b1;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (proc_fire) begin
         cnt_in = cnt_in + CNT_W'(n_res);
      end
      if (rsp_pop) begin
         cnt_in = cnt_in - CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         sync_ff     <= '0;
         phase_ff    <= PH_HUNT;
         accum_ff    <= '0;
         biw_ff      <= '0;
         hwc_ff      <= '0;
         decl_len_ff <= '0;
         tlvs_ff     <= '0;
         tlv_type_ff <= '0;
         pay_rem_ff  <= '0;
         span_ff     <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (proc_fire) begin
            sync_ff     <= sync_in;
            phase_ff    <= phase_in;
            accum_ff    <= accum_in;
            biw_ff      <= biw_in;
            hwc_ff      <= hwc_in;
            decl_len_ff <= decl_len_in;
            tlvs_ff     <= tlvs_in;
            tlv_type_ff <= tlv_type_in;
            pay_rem_ff  <= pay_rem_in;
            span_ff     <= span_in;
            wr_ptr_ff   <= wr_ptr_ff + PTR_W'(n_res);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (proc_fire && (n_res != 2'd0)) begin
         rsp_q_ff[wr_ptr_ff] <= res_a;
      end
      if (proc_fire && (n_res == 2'd2)) begin
         rsp_q_ff[wr_ptr_ff + PTR_W'(1)] <= res_b;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tuser  = rsp_q_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = rsp_q_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {2'b00,
                        rsp_q_ff[rd_ptr_ff].frame_ok,
                        rsp_q_ff[rd_ptr_ff].tlv_last_byte,
                        rsp_q_ff[rd_ptr_ff].tlv_kind,
                        rsp_q_ff[rd_ptr_ff].value,
                        rsp_q_ff[rd_ptr_ff].word_index};

   // The result queue never overfills.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // A parsed buffer-end byte always leaves the parser hunting.
   assert property (@(posedge clock) disable iff (reset)
      (proc_fire && in_end_ff) |=> (phase_ff == PH_HUNT))
      else $error("buffer end did not close the frame");

   // An open frame has counted at least its sync pattern.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HUNT) |-> (span_ff >= SYNC_LEN))
      else $error("frame span below sync length");

   // A waiting result holds still until the consumer takes it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

endmodule

`default_nettype wire
